FILE: rtl/kst_pkg.sv
`default_nettype none

package kst_pkg;

   localparam int KEY_W         = 32;
   localparam int SLOT_W        = 4;
   localparam int SLOTS_DEFAULT = 16;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_LOOKUP = 2'd1,
      OP_DELETE = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK   = 2'd0,
      STAT_DUP  = 2'd1,
      STAT_FULL = 2'd2,
      STAT_MISS = 2'd3
   } status_type;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   typedef struct packed {
      op_type                   operation;
      logic signed [KEY_W-1:0]  key;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic [SLOT_W-1:0]   slot;
   } rsp_type;

endpackage

`default_nettype wire

FILE: rtl/kst_key_ram.sv
`default_nettype none

module kst_key_ram #(
   parameter int DEPTH = kst_pkg::SLOTS_DEFAULT,
   parameter int AW    = $clog2(kst_pkg::SLOTS_DEFAULT)
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [AW-1:0]            wr_addr,
   input  wire logic [kst_pkg::KEY_W-1:0] wr_data,
   input  wire logic [AW-1:0]            rd_addr,
   output logic [kst_pkg::KEY_W-1:0]      rd_data
);
   import kst_pkg::*;

   logic [KEY_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

FILE: rtl/keyed_slot_table.sv
`default_nettype none

// Keyed slot table: a request (add, lookup, delete, clear) is taken when start is high and
// busy is low. Keys sit in a single-port-read key memory that is swept one slot per cycle,
// lowest index first, for add, lookup and delete: the sweep stops at the first valid slot
// with a matching key, otherwise runs through all SLOTS slots. Clear needs no sweep.
// Each request gives exactly one result, shown for one cycle with
// rsp_valid high; the receiver cannot stall it, so it must take every result as it comes.
// Valid bits live in flip-flops and reset clears them at once, with no clearing pass.

module keyed_slot_table #(
   parameter int SLOTS = kst_pkg::SLOTS_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire kst_pkg::req_type req,
   output logic                  rsp_valid,
   output kst_pkg::rsp_type      rsp
);
   import kst_pkg::*;

   localparam int IDX_W = $clog2(SLOTS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

   state_type          state_ff, state_in;
   op_type             op_ff;
   logic [KEY_W-1:0]   key_ff;
   logic [IDX_W-1:0]   addr_ff;
   logic               free_found_ff;
   logic [IDX_W-1:0]   free_idx_ff;
   logic [SLOTS-1:0]   valid_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   logic               accept;
   logic [IDX_W-1:0]   rd_addr;
   logic [KEY_W-1:0]   rd_data;
   logic               cur_valid;
   logic               cur_match;
   logic               cur_free;
   logic               finish;
   logic               have_free;
   logic [IDX_W-1:0]   free_sel;
   logic               wr_en;
   status_type         res_status;
   logic [IDX_W-1:0]   res_idx;
   logic [IDX_W+SLOT_W-1:0] res_ext;

   kst_key_ram #(
      .DEPTH (SLOTS),
      .AW    (IDX_W)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (free_sel),
      .wr_data (key_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req.operation != OP_CLEAR) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (finish) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // scan datapath and result
   always_comb begin
      rd_addr    = accept ? '0 : addr_ff + 1'b1;
      cur_valid  = valid_ff[addr_ff];
      cur_match  = cur_valid && (rd_data == key_ff);
      cur_free   = !cur_valid;
      finish     = (state_ff == ST_SCAN) && (cur_match || addr_ff == LAST_IDX);
      have_free  = free_found_ff || cur_free;
      free_sel   = free_found_ff ? free_idx_ff : addr_ff;
      res_status = STAT_OK;
      res_idx    = '0;
      case (op_ff)
         OP_ADD: begin
            if (cur_match) begin
               res_status = STAT_DUP;
            end else if (have_free) begin
               res_idx = free_sel;
            end else begin
               res_status = STAT_FULL;
            end
         end
         OP_LOOKUP, OP_DELETE: begin
            if (cur_match) begin
               res_idx = addr_ff;
            end else begin
               res_status = STAT_MISS;
            end
         end
         default: begin
            res_status = STAT_OK;
         end
      endcase
      res_ext = {{SLOT_W{1'b0}}, res_idx};
      wr_en   = finish && op_ff == OP_ADD && !cur_match && have_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (accept && req.operation == OP_CLEAR) || finish;
         if (accept && req.operation == OP_CLEAR) begin
            valid_ff <= '0;
         end else if (wr_en) begin
            valid_ff[free_sel] <= 1'b1;
         end else if (finish && op_ff == OP_DELETE && cur_match) begin
            valid_ff[addr_ff] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff         <= req.operation;
         key_ff        <= $unsigned(req.key);
         addr_ff       <= '0;
         free_found_ff <= 1'b0;
      end else if (state_ff == ST_SCAN) begin
         addr_ff <= addr_ff + 1'b1;
         if (cur_free && !free_found_ff) begin
            free_found_ff <= 1'b1;
            free_idx_ff   <= addr_ff;
         end
      end
      if (accept && req.operation == OP_CLEAR) begin
         rsp_ff.status <= STAT_OK;
         rsp_ff.slot   <= '0;
      end else begin
         rsp_ff.status <= res_status;
         rsp_ff.slot   <= res_ext[SLOT_W-1:0];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

`default_nettype wire
